// ===== hdl/rlepd_pkg.sv =====
package rlepd_pkg;

    localparam int PIXEL_BYTES = 3;

    localparam int PIX_BYTES_CLAMPED =
        (PIXEL_BYTES < 1) ? 1 : ((PIXEL_BYTES > 4) ? 4 : PIXEL_BYTES);

    // bytes of a colour pixel that must be held before the final one arrives
    localparam int HELD_BYTES =
        (PIX_BYTES_CLAMPED >= 4) ? 3 :
        ((PIX_BYTES_CLAMPED < 2) ? 1 : PIX_BYTES_CLAMPED - 1);

    localparam int HELD_W = 8 * HELD_BYTES;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_COUNT  = 2'd1,
        PH_PIXEL  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] channel_zero;
        logic [7:0] channel_one;
        logic [7:0] channel_two;
        logic [7:0] repeat_count;
    } pixel_t;

endpackage

// ===== hdl/rlepd_if.sv =====
interface rlepd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface rlepd_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] channel_zero;
    logic [7:0] channel_one;
    logic [7:0] channel_two;
    logic [7:0] repeat_count;

    modport source (output valid, output channel_zero, output channel_one,
                    output channel_two, output repeat_count, input ready);
    modport sink (input valid, input channel_zero, input channel_one,
                  input channel_two, input repeat_count, output ready);
endinterface

// ===== hdl/rlepd_parser.sv =====
module rlepd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          byte_data,
    input  logic                gray_mode,
    output logic                emit,
    output rlepd_pkg::pixel_t   pixel
);

    rlepd_pkg::phase_t                 phase_reg, phase_next;
    logic [7:0]                        lit_reg, lit_next;
    logic [7:0]                        run_reg, run_next;
    logic [1:0]                        pos_reg, pos_next;
    logic [rlepd_pkg::HELD_W-1:0]      held_reg, held_next;

    logic [7:0]                        lit_dec;
    logic [2:0]                        pos_inc;
    logic [7:0]                        chan [3];

    assign lit_dec = lit_reg - 8'd1;
    assign pos_inc = {1'b0, pos_reg} + 3'd1;

    // colour channels: current byte at its position, earlier bytes from holding
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            chan[i] = 8'd0;
            if (i < rlepd_pkg::HELD_BYTES)
            begin
                chan[i] = held_reg[8*i +: 8];
            end
            if (pos_reg == 2'(i))
            begin
                chan[i] = byte_data;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        lit_next   = lit_reg;
        run_next   = run_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        emit       = 1'b0;
        pixel      = '0;

        unique case (phase_reg)
            rlepd_pkg::PH_COUNT:
            begin
                lit_next   = byte_data;
                pos_next   = 2'd0;
                held_next  = '0;
                phase_next = (byte_data == 8'd0) ? rlepd_pkg::PH_HEADER
                                                 : rlepd_pkg::PH_PIXEL;
            end
            rlepd_pkg::PH_PIXEL:
            begin
                if (gray_mode || (pos_inc >= 3'(rlepd_pkg::PIX_BYTES_CLAMPED)))
                begin
                    emit = 1'b1;
                    if (gray_mode)
                    begin
                        pixel.channel_zero = byte_data;
                        pixel.channel_one  = byte_data;
                        pixel.channel_two  = byte_data;
                    end
                    else
                    begin
                        pixel.channel_zero = chan[0];
                        pixel.channel_one  = chan[1];
                        pixel.channel_two  = chan[2];
                    end
                    if (run_reg != 8'd0)
                    begin
                        pixel.repeat_count = run_reg;
                        phase_next         = rlepd_pkg::PH_HEADER;
                    end
                    else
                    begin
                        pixel.repeat_count = 8'd1;
                        lit_next           = lit_dec;
                        if (lit_dec == 8'd0)
                        begin
                            phase_next = rlepd_pkg::PH_HEADER;
                        end
                    end
                    pos_next  = 2'd0;
                    held_next = '0;
                end
                else
                begin
                    for (int j = 0; j < rlepd_pkg::HELD_BYTES; j++)
                    begin
                        if (pos_reg == 2'(j))
                        begin
                            held_next[8*j +: 8] = byte_data;
                        end
                    end
                    pos_next = pos_inc[1:0];
                end
            end
            default:
            begin
                run_next   = byte_data;
                pos_next   = 2'd0;
                held_next  = '0;
                phase_next = (byte_data == 8'd0) ? rlepd_pkg::PH_COUNT
                                                 : rlepd_pkg::PH_PIXEL;
            end
        endcase

        if (!advance)
        begin
            emit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rlepd_pkg::PH_HEADER;
            lit_reg   <= 8'd0;
            run_reg   <= 8'd0;
            pos_reg   <= 2'd0;
            held_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            run_reg   <= run_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== hdl/rle_pixel_stream_decoder_unit.sv =====
// Structure: an accepted byte is registered in the input register and decoded by the
// combinational parser; its pixel, if any, is then registered in the output register.
// Throughput: one stream byte per cycle while pixels are taken; a pixel waiting on ready
// holds the input register, so the stream stalls once that register is full.
// Reset (rst_n, async, active low) returns the parser to header phase, clears the
// held channels and counts, empties both registers and sets gray_mode to 0.
module rle_pixel_stream_decoder_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    rlepd_byte_if.sink           stream,
    rlepd_pixel_if.source        pixel,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata
);

    logic                 gray_reg;
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    rlepd_pkg::pixel_t    out_pix_reg;

    logic                 out_free;
    logic                 advance;
    logic                 emit;
    rlepd_pkg::pixel_t    pix;

    assign out_free     = !out_valid_reg || pixel.ready;
    assign advance      = in_valid_reg && out_free;
    assign stream.ready = !in_valid_reg || advance;

    rlepd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .byte_data (in_byte_reg),
        .gray_mode (gray_reg),
        .emit      (emit),
        .pixel     (pix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gray_reg <= cfg_wdata;
            end
            if (stream.ready)
            begin
                in_valid_reg <= stream.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_byte_reg <= stream.stream_byte;
        end
        if (emit)
        begin
            out_pix_reg <= pix;
        end
    end

    assign pixel.valid        = out_valid_reg;
    assign pixel.channel_zero = out_pix_reg.channel_zero;
    assign pixel.channel_one  = out_pix_reg.channel_one;
    assign pixel.channel_two  = out_pix_reg.channel_two;
    assign pixel.repeat_count = out_pix_reg.repeat_count;

endmodule

// ===== bench/rle_pixel_stream_decoder_unit_tb.sv =====
`timescale 1ns / 100ps

module rle_pixel_stream_decoder_unit_tb;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    rlepd_byte_if  stream_if ();
    rlepd_pixel_if pixel_if ();

    rle_pixel_stream_decoder_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_if),
        .pixel     (pixel_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // decoder state mirror
    logic               gray_sel   = 1'b0;
    rlepd_pkg::phase_t  parse_ph   = rlepd_pkg::PH_HEADER;
    logic [7:0]         lit_left   = 8'd0;
    logic [7:0]         run_len    = 8'd0;
    logic [1:0]         chan_pos   = 2'd0;
    logic [23:0]        held_bytes = 24'd0;

    rlepd_pkg::pixel_t  pixel_expect_q [$];
    int unsigned        fail_count = 0;
    int unsigned        bytes_sent = 0;
    bit                 throttle_on = 1'b1;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic emit_pixel(input logic [7:0] c0, input logic [7:0] c1,
                              input logic [7:0] c2);
        rlepd_pkg::pixel_t px;
        px.channel_zero = c0;
        px.channel_one  = c1;
        px.channel_two  = c2;
        if (run_len != 8'd0)
        begin
            px.repeat_count = run_len;
            parse_ph = rlepd_pkg::PH_HEADER;
        end
        else
        begin
            px.repeat_count = 8'd1;
            lit_left = lit_left - 8'd1;
            if (lit_left == 8'd0)
                parse_ph = rlepd_pkg::PH_HEADER;
        end
        chan_pos   = 2'd0;
        held_bytes = 24'd0;
        pixel_expect_q = {pixel_expect_q, px};
    endtask

    task automatic decode_stream_byte(input logic [7:0] b);
        case (parse_ph)
            rlepd_pkg::PH_COUNT:
            begin
                lit_left   = b;
                chan_pos   = 2'd0;
                held_bytes = 24'd0;
                parse_ph   = (b == 8'd0) ? rlepd_pkg::PH_HEADER : rlepd_pkg::PH_PIXEL;
            end
            rlepd_pkg::PH_PIXEL:
            begin
                if (gray_sel)
                    emit_pixel(b, b, b);
                else
                begin
                    if (chan_pos < 2'd3)
                        held_bytes = held_bytes | (24'(b) << (8 * chan_pos));
                    if (int'(chan_pos) + 1 >= rlepd_pkg::PIX_BYTES_CLAMPED)
                        emit_pixel(held_bytes[7:0], held_bytes[15:8], held_bytes[23:16]);
                    else
                        chan_pos = chan_pos + 2'd1;
                end
            end
            default:
            begin
                run_len    = b;
                chan_pos   = 2'd0;
                held_bytes = 24'd0;
                parse_ph   = (b == 8'd0) ? rlepd_pkg::PH_COUNT : rlepd_pkg::PH_PIXEL;
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                gray_sel = cfg_wdata;
            if (stream_if.valid && stream_if.ready)
                decode_stream_byte(stream_if.stream_byte);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_pixel
        rlepd_pkg::pixel_t want;
        if (rst_n && pixel_if.valid && pixel_if.ready)
        begin
            if (pixel_expect_q.size() == 0)
            begin
                $error("unexpected pixel transaction: %0h %0h %0h repeat %0d",
                       pixel_if.channel_zero, pixel_if.channel_one,
                       pixel_if.channel_two, pixel_if.repeat_count);
                fail_count++;
            end
            else
            begin
                want = pixel_expect_q.pop_front();
                check_field("channel_zero", want.channel_zero, pixel_if.channel_zero);
                check_field("channel_one", want.channel_one, pixel_if.channel_one);
                check_field("channel_two", want.channel_two, pixel_if.channel_two);
                check_field("repeat_count", want.repeat_count, pixel_if.repeat_count);
            end
        end
    end

    always @(negedge clk)
        pixel_if.ready <= !throttle_on || ($urandom_range(99) >= 24);

    // entered and left at a falling edge; valid stays high for back-to-back bytes unless the throttle inserts a gap
    task automatic send_byte(input logic [7:0] b);
        while (throttle_on && $urandom_range(99) < 24)
        begin
            stream_if.valid <= 1'b0;
            @(negedge clk);
        end
        stream_if.valid       <= 1'b1;
        stream_if.stream_byte <= b;
        do
            @(posedge clk);
        while (!stream_if.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_pixel_bytes();
        int unsigned n;
        n = gray_sel ? 1 : rlepd_pkg::PIX_BYTES_CLAMPED;
        repeat (n)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic set_gray(input logic v);
        stream_if.valid <= 1'b0;
        while (pixel_expect_q.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic test_colour_runs();
        set_gray(1'b0);
        send_byte(8'd255);
        send_byte(8'hff);
        send_byte(8'hff);
        send_byte(8'hff);
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(8'd2);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7f);
    endtask

    task automatic test_gray_runs();
        set_gray(1'b1);
        send_byte(8'd1);
        send_byte(8'h00);
        send_byte(8'd0);
        send_byte(8'd1);
        send_byte(8'hff);
    endtask

    task automatic test_mode_switch_mid_pixel();
        set_gray(1'b0);
        send_byte(8'd7);
        send_byte(8'h0a);
        set_gray(1'b1);
        send_byte(8'h0c);
        send_byte(8'd0);
        send_byte(8'd2);
        send_byte(8'h0d);
        set_gray(1'b0);
        send_byte(8'h0e);
        send_byte(8'h0f);
        send_byte(8'h10);
    endtask

    task automatic send_random_group();
        int unsigned pick;
        int unsigned count;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            send_byte(8'($urandom_range(1, 255)));
            send_pixel_bytes();
        end
        else if (pick < 85)
        begin
            count = (gray_sel && $urandom_range(29) == 0) ? 255 : $urandom_range(1, 12);
            send_byte(8'd0);
            send_byte(8'(count));
            repeat (count)
                send_pixel_bytes();
        end
        else if (pick < 90)
        begin
            send_byte(8'd0);
            send_byte(8'd0);
        end
        else
        begin
            repeat ($urandom_range(1, 5))
                send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_stream();
        int unsigned stop_at;
        for (int phase = 0; phase < 6; phase++)
        begin
            set_gray(phase[0]);
            throttle_on = (phase != 2);
            stop_at = bytes_sent + 175;
            while (bytes_sent < stop_at)
                send_random_group();
        end
        throttle_on = 1'b1;
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = 1'b0;
        stream_if.valid       = 1'b0;
        stream_if.stream_byte = 8'd0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_colour_runs();
        test_gray_runs();
        test_mode_switch_mid_pixel();
        test_random_stream();

        stream_if.valid <= 1'b0;
        for (int i = 0; i < 20000 && pixel_expect_q.size() != 0; i++)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (pixel_expect_q.size() != 0)
        begin
            $error("%0d expected pixels never arrived", pixel_expect_q.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
